### rtl/history_ring_lagrange_predictor_core_defines.svh
// Assertion macros shared by the history ring predictor RTL.
`ifndef HISTORY_RING_LAGRANGE_PREDICTOR_CORE_DEFINES_SVH
`define HISTORY_RING_LAGRANGE_PREDICTOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define HRLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define HRLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hrlp_pkg.sv
// Package: item types, operation codes, register indexes and saturation helpers.
`timescale 1ns / 1ps

package hrlp_pkg;

    localparam int STEPS_DEF     = 8;
    localparam int VARS_DEF      = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Operation codes
    localparam logic [3:0] OP_WR_ELEM = 4'd0;
    localparam logic [3:0] OP_RD_ELEM = 4'd1;
    localparam logic [3:0] OP_WR_TIME = 4'd2;
    localparam logic [3:0] OP_RD_TIME = 4'd3;
    localparam logic [3:0] OP_PROCEED = 4'd4;
    localparam logic [3:0] OP_PREDICT = 4'd5;
    localparam logic [3:0] OP_ERROR   = 4'd6;
    localparam logic [3:0] OP_COUNT   = 4'd7;
    localparam logic [3:0] OP_RESTART = 4'd8;

    // Configuration register indexes
    localparam logic CFG_PRED_ORDER = 1'b0;
    localparam logic CFG_MAX_STEP   = 1'b1;

    localparam logic [2:0]  PRED_ORDER_RST = 3'd2;
    localparam logic [30:0] MAX_STEP_RST   = 31'd65536;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [3:0]  offset;
        logic [3:0]         var_index;
        logic signed [31:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [3:0]         seq_count;
        logic               div_fault;
    } out_item_t;

    // Clamp a 33-bit signed value to 32 bits
    function automatic logic signed [31:0] sat_s33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -33'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Clamp a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat_s64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/hrlp_rdiv.sv
// Bit-serial signed divider, round to nearest (ties away), 32-bit saturated quotient.
`timescale 1ns / 1ps

module hrlp_rdiv
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        dvd_reg;
    logic [31:0]        rem_reg;
    logic [32:0]        dsr_reg;
    logic               neg_reg;
    logic signed [31:0] quot_reg;

    logic [63:0] num_mag;
    logic [32:0] den_mag;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_new;
    logic [63:0] dvd_new;
    logic signed [31:0] quot_sat;

    // Operand magnitudes
    always_comb
    begin
        num_mag = num[63] ? 64'(-num) : 64'(num);
        den_mag = den[31] ? 33'(-$signed({den[31], den})) : {1'b0, den};
    end

    // One restoring step and the final saturation
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[63]};
        ge      = (rem_sh >= dsr_reg);
        rem_new = ge ? (rem_sh - dsr_reg) : rem_sh;
        dvd_new = {dvd_reg[62:0], ge};
        if (!neg_reg)
            quot_sat = (dvd_new > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                            : $signed(dvd_new[31:0]);
        else
            quot_sat = (dvd_new > 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                            : $signed(-dvd_new[31:0]);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: half the divisor is added up front for rounding
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= num_mag + 64'(den_mag >> 1);
            dsr_reg <= den_mag;
            rem_reg <= '0;
            neg_reg <= num[63] ^ den[31];
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_new;
            rem_reg <= rem_new[31:0];
            if (cnt_reg == 6'd63)
                quot_reg <= quot_sat;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/hrlp_isqrt.sv
// Iterative 64-bit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module hrlp_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] n_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [31:0] root_reg;

    logic [63:0] trial;
    logic        fits;
    logic [63:0] res_new;

    always_comb
    begin
        trial   = res_reg + bit_reg;
        fits    = (n_reg >= trial);
        res_new = fits ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (fits)
                n_reg <= n_reg - trial;
            res_reg <= res_new;
            bit_reg <= bit_reg >> 2;
            if (bit_reg == 64'd1)
                root_reg <= res_new[31:0];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/history_ring_lagrange_predictor_core.sv
// Top level: history ring with Lagrange extrapolation, element memory and sequencer.
//
//  Channel  Signals                      Direction  Content
//  in       in_valid, in_stall, in_data  in         one operation per transfer
//  out      out_valid, out_stall, out_data out      one result per operation
//  cfg      cfg_valid, cfg_ready,        in         register index, write data
//           cfg_index, cfg_data
//
// One operation is in work at a time. Element and time access, proceed and
// restart pass through EXEC and DONE (element read adds RDWAIT between them);
// count walks back through the ring in CNT.
// Predict builds each coefficient factor by factor through CI, CM, CD0 and
// CDW, where it waits on the bit-serial divider.
// Error adds ER and ES per element and then waits on the square root.
// After reset the element memory is cleared, one entry a cycle, over all
// STEPS*VARS entries while in_stall stays high.
// A finished result sits in the output register; the next operation is
// taken while it waits, and finishes only once that register is free.
`timescale 1ns / 1ps
`include "history_ring_lagrange_predictor_core_defines.svh"

module history_ring_lagrange_predictor_core
#(
    parameter int STEPS     = hrlp_pkg::STEPS_DEF,
    parameter int VARS      = hrlp_pkg::VARS_DEF,
    parameter int FRAC_BITS = hrlp_pkg::FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hrlp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hrlp_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);

    import hrlp_pkg::*;

    localparam int HW    = $clog2(STEPS);
    localparam int VIW   = (VARS > 1) ? $clog2(VARS) : 1;
    localparam int DEPTH = STEPS * VARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(STEPS);

    localparam logic signed [8:0] OFF_LO  = 9'(2 - STEPS);
    localparam logic signed [8:0] STEPS_S = 9'(STEPS);
    localparam logic [HW-1:0]     HEAD_MAX = HW'(STEPS - 1);
    localparam logic [HW-1:0]     CI_LAST  = HW'(STEPS - 2);
    localparam logic [AW-1:0]     VARS_A   = AW'(VARS);
    localparam logic [AW-1:0]     ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [VIW-1:0]    V_LAST   = VIW'(VARS - 1);
    localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
    localparam logic [63:0]       HALF_LSB = 64'd1 << (FRAC_BITS - 1);

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_EXEC   = 5'd1;
    localparam logic [4:0] S_RDWAIT = 5'd2;
    localparam logic [4:0] S_NEWX   = 5'd3;
    localparam logic [4:0] S_CJ     = 5'd4;
    localparam logic [4:0] S_CI     = 5'd5;
    localparam logic [4:0] S_CM     = 5'd6;
    localparam logic [4:0] S_CD0    = 5'd7;
    localparam logic [4:0] S_CDW    = 5'd8;
    localparam logic [4:0] S_EA     = 5'd9;
    localparam logic [4:0] S_EB     = 5'd10;
    localparam logic [4:0] S_EC     = 5'd11;
    localparam logic [4:0] S_EF     = 5'd12;
    localparam logic [4:0] S_ER     = 5'd13;
    localparam logic [4:0] S_ES     = 5'd14;
    localparam logic [4:0] S_SQ0    = 5'd15;
    localparam logic [4:0] S_SQW    = 5'd16;
    localparam logic [4:0] S_CNT    = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    // Ring slot of an offset from a head: clamp, then wrap
    function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] hd,
                                              input logic signed [8:0] off);
        logic signed [8:0] o;
        logic signed [8:0] s;
        o = off;
        if (o < OFF_LO)
            o = OFF_LO;
        if (o > 9'sd1)
            o = 9'sd1;
        s = $signed({{(9 - HW){1'b0}}, hd}) + o;
        if (s >= STEPS_S)
            s = s - STEPS_S;
        if (s < 9'sd0)
            s = s + STEPS_S;
        return s[HW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [HW-1:0] s,
                                              input logic [VIW-1:0] v);
        return AW'(s) * VARS_A + AW'(v);
    endfunction

    // Configuration
    logic [2:0]  pred_order_reg;
    logic [30:0] max_step_reg;

    // Sequencer and datapath registers
    logic [4:0]         state_reg, state_next;
    logic [3:0]         op_reg, op_next;
    logic [HW-1:0]      slot_reg, slot_next;
    logic [3:0]         var_reg, var_next;
    logic signed [31:0] data_reg, data_next;
    logic [HW-1:0]      head_reg, head_next;
    logic [2:0]         order_reg, order_next;
    logic signed [31:0] newx_reg, newx_next;
    logic [3:0]         j_reg, j_next;
    logic [3:0]         i_reg, i_next;
    logic [3:0]         k_reg, k_next;
    logic [VIW-1:0]     v_reg, v_next;
    logic signed [31:0] xj_reg, xj_next;
    logic signed [31:0] num_reg, num_next;
    logic signed [31:0] den_reg, den_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] pred_reg, pred_next;
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        sum_reg, sum_next;
    logic               fault_reg, fault_next;
    logic signed [31:0] rv_reg, rv_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [HW-1:0]      ci_reg, ci_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    // Time stamps and coefficients
    logic signed [31:0] time_reg [STEPS];
    logic signed [31:0] coef_reg [STEPS];
    logic               time_we;
    logic               time_clr;
    logic [HW-1:0]      time_waddr;
    logic signed [31:0] time_wdata;
    logic [HW-1:0]      t_addr;
    logic signed [31:0] t_rd;
    logic               coef_we;

    // Element memory
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] mem_rdata_reg;
    logic               clr_busy_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               fsm_we;
    logic [AW-1:0]      fsm_waddr;
    logic signed [31:0] fsm_wdata;
    logic [AW-1:0]      mem_raddr;

    // Shared units
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;

    // Helpers
    logic               in_xfer;
    logic               var_ok;
    logic [2:0]         eff_order;
    logic [HW-1:0]      slot_p1;
    logic signed [8:0]  j_off, i_off, k_off, c_off;
    logic [63:0]        pmag, rmag;
    logic signed [63:0] term;
    logic signed [32:0] diff33;
    logic [32:0]        dmag;
    logic [64:0]        sum65;
    logic signed [32:0] cdiff;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || clr_busy_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign var_ok  = (32'(var_reg) < 32'(VARS));
    assign slot_p1 = slot_of(head_reg, 9'sd1);
    assign j_off   = $signed({5'b0, j_reg}) - $signed({6'b0, order_reg});
    assign i_off   = $signed({5'b0, i_reg}) - $signed({6'b0, order_reg});
    assign k_off   = $signed({5'b0, k_reg}) - $signed({6'b0, order_reg});
    assign c_off   = -$signed({{(9 - HW){1'b0}}, ci_reg}) - 9'sd1;

    // Order in use, clamped to 1..STEPS-2
    always_comb
    begin
        if (pred_order_reg == 3'd0)
            eff_order = 3'd1;
        else if (32'(pred_order_reg) > 32'(STEPS - 2))
            eff_order = 3'(STEPS - 2);
        else
            eff_order = pred_order_reg;
    end

    // Time read port
    always_comb
    begin
        case (state_reg)
            S_EXEC:  t_addr = (op_reg == OP_RD_TIME) ? slot_reg : head_reg;
            S_NEWX:  t_addr = (op_reg == OP_PREDICT) ? head_reg : slot_p1;
            S_CJ:    t_addr = slot_of(head_reg, j_off);
            S_CI:    t_addr = slot_of(head_reg, i_off);
            S_CNT:   t_addr = slot_of(head_reg, c_off);
            default: t_addr = head_reg;
        endcase
        t_rd = time_reg[t_addr];
    end

    // Product rounded back to Q format, ties away from zero
    always_comb
    begin
        pmag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        rmag = (pmag + HALF_LSB) >> FRAC_BITS;
        term = prod_reg[63] ? -$signed(rmag) : $signed(rmag);
    end

    // Error term and count gap
    always_comb
    begin
        diff33 = $signed({pred_reg[31], pred_reg})
                 - $signed({mem_rdata_reg[31], mem_rdata_reg});
        dmag   = diff33[32] ? 33'(-diff33) : 33'(diff33);
        sum65  = {1'b0, sum_reg} + {1'b0, sq_reg};
        cdiff  = $signed({prev_reg[31], prev_reg}) - $signed({t_rd[31], t_rd});
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        var_next       = var_reg;
        data_next      = data_reg;
        head_next      = head_reg;
        order_next     = order_reg;
        newx_next      = newx_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        xj_next        = xj_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        c_next         = c_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        pred_next      = pred_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        fault_next     = fault_reg;
        rv_next        = rv_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        ci_next        = ci_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        time_we        = 1'b0;
        time_clr       = 1'b0;
        time_waddr     = slot_reg;
        time_wdata     = data_reg;
        coef_we        = 1'b0;
        fsm_we         = 1'b0;
        fsm_waddr      = addr_of(slot_reg, VIW'(var_reg));
        fsm_wdata      = data_reg;
        mem_raddr      = addr_of(slot_reg, VIW'(var_reg));
        div_start      = 1'b0;
        sq_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = in_data.operation;
                    slot_next  = slot_of(head_reg, {{5{in_data.offset[3]}}, in_data.offset});
                    var_next   = in_data.var_index;
                    data_next  = in_data.data_value;
                    order_next = eff_order;
                    fault_next = 1'b0;
                    rv_next    = '0;
                    cnt_next   = '0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_WR_ELEM:
                    begin
                        fsm_we = var_ok;
                    end
                    OP_RD_ELEM:
                    begin
                        state_next = S_RDWAIT;
                    end
                    OP_WR_TIME:
                    begin
                        time_we = 1'b1;
                    end
                    OP_RD_TIME:
                    begin
                        rv_next = t_rd;
                    end
                    OP_PROCEED:
                    begin
                        if (data_reg != 32'sd0)
                        begin
                            if (!data_reg[31])
                                head_next = (head_reg == HEAD_MAX) ? '0 : head_reg + 1'b1;
                            else
                                head_next = (head_reg == '0) ? HEAD_MAX : head_reg - 1'b1;
                            time_we    = 1'b1;
                            time_waddr = head_next;
                            time_wdata = sat_s33($signed({t_rd[31], t_rd})
                                                 + $signed({data_reg[31], data_reg}));
                        end
                    end
                    OP_PREDICT, OP_ERROR:
                    begin
                        state_next = S_NEWX;
                    end
                    OP_COUNT:
                    begin
                        prev_next  = t_rd;
                        cnt_next   = CW'(1);
                        ci_next    = '0;
                        state_next = S_CNT;
                    end
                    OP_RESTART:
                    begin
                        time_clr = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RDWAIT:
            begin
                rv_next    = var_ok ? mem_rdata_reg : 32'sd0;
                state_next = S_DONE;
            end

            // Abscissa of the extrapolated slot
            S_NEWX:
            begin
                if (op_reg == OP_PREDICT)
                    newx_next = sat_s33($signed({t_rd[31], t_rd})
                                        + $signed({data_reg[31], data_reg}));
                else
                    newx_next = t_rd;
                sum_next   = '0;
                j_next     = '0;
                state_next = S_CJ;
            end

            // Coefficient build: one factor per pass through CI..CDW
            S_CJ:
            begin
                xj_next    = t_rd;
                c_next     = ONE_Q;
                i_next     = '0;
                state_next = S_CI;
            end

            S_CI:
            begin
                if (i_reg > {1'b0, order_reg})
                begin
                    coef_we = 1'b1;
                    if (j_reg == {1'b0, order_reg})
                    begin
                        v_next     = '0;
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = S_EA;
                    end
                    else
                    begin
                        j_next     = j_reg + 4'd1;
                        state_next = S_CJ;
                    end
                end
                else if (i_reg == j_reg)
                begin
                    i_next = i_reg + 4'd1;
                end
                else
                begin
                    num_next   = sat_s33($signed({newx_reg[31], newx_reg})
                                         - $signed({t_rd[31], t_rd}));
                    den_next   = sat_s33($signed({xj_reg[31], xj_reg})
                                         - $signed({t_rd[31], t_rd}));
                    state_next = S_CM;
                end
            end

            S_CM:
            begin
                if (den_reg == 32'sd0)
                begin
                    fault_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    prod_next  = c_reg * num_reg;
                    state_next = S_CD0;
                end
            end

            S_CD0:
            begin
                div_start  = 1'b1;
                state_next = S_CDW;
            end

            S_CDW:
            begin
                if (div_done)
                begin
                    c_next     = div_quot;
                    i_next     = i_reg + 4'd1;
                    state_next = S_CI;
                end
            end

            // Element phase: read, multiply, accumulate per point
            S_EA:
            begin
                mem_raddr  = addr_of(slot_of(head_reg, k_off), v_reg);
                state_next = S_EB;
            end

            S_EB:
            begin
                prod_next  = mem_rdata_reg * coef_reg[k_reg[HW-1:0]];
                state_next = S_EC;
            end

            S_EC:
            begin
                acc_next = acc_reg + term;
                if (k_reg == {1'b0, order_reg})
                    state_next = S_EF;
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_EA;
                end
            end

            S_EF:
            begin
                if (op_reg == OP_PREDICT)
                begin
                    fsm_we    = 1'b1;
                    fsm_waddr = addr_of(slot_p1, v_reg);
                    fsm_wdata = sat_s64(acc_reg);
                    if (v_reg == V_LAST)
                    begin
                        time_we    = 1'b1;
                        time_waddr = slot_p1;
                        time_wdata = newx_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        v_next     = v_reg + 1'b1;
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = S_EA;
                    end
                end
                else
                begin
                    pred_next  = sat_s64(acc_reg);
                    mem_raddr  = addr_of(slot_p1, v_reg);
                    state_next = S_ER;
                end
            end

            S_ER:
            begin
                sq_next    = dmag[31:0] * dmag[31:0];
                state_next = S_ES;
            end

            S_ES:
            begin
                sum_next = sum65[64] ? '1 : sum65[63:0];
                if (v_reg == V_LAST)
                    state_next = S_SQ0;
                else
                begin
                    v_next     = v_reg + 1'b1;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = S_EA;
                end
            end

            S_SQ0:
            begin
                sq_start   = 1'b1;
                state_next = S_SQW;
            end

            S_SQW:
            begin
                if (sq_done)
                begin
                    rv_next    = sq_root[31] ? 32'sh7FFF_FFFF : $signed(sq_root);
                    state_next = S_DONE;
                end
            end

            // Walk back from the head while times keep rising within max_step
            S_CNT:
            begin
                if (cdiff <= 33'sd0 || cdiff > $signed({2'b0, max_step_reg}))
                    state_next = S_DONE;
                else
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    prev_next = t_rd;
                    if (ci_reg == CI_LAST)
                        state_next = S_DONE;
                    else
                        ci_next = ci_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.read_value = rv_reg;
                    out_data_next.seq_count  = 4'(cnt_reg);
                    out_data_next.div_fault  = fault_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        var_reg      <= var_next;
        data_reg     <= data_next;
        order_reg    <= order_next;
        newx_reg     <= newx_next;
        j_reg        <= j_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        v_reg        <= v_next;
        xj_reg       <= xj_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        c_reg        <= c_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        pred_reg     <= pred_next;
        sq_reg       <= sq_next;
        sum_reg      <= sum_next;
        fault_reg    <= fault_next;
        rv_reg       <= rv_next;
        cnt_reg      <= cnt_next;
        prev_reg     <= prev_next;
        ci_reg       <= ci_next;
        out_data_reg <= out_data_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_order_reg <= PRED_ORDER_RST;
            max_step_reg   <= MAX_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PRED_ORDER: pred_order_reg <= cfg_data[2:0];
                CFG_MAX_STEP:   max_step_reg   <= cfg_data[30:0];
                default:        pred_order_reg <= pred_order_reg;
            endcase
        end
    end

    // Time stamps: reset and restart clear them all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < STEPS; n++)
                time_reg[n] <= '0;
        end
        else if (time_clr)
        begin
            for (int n = 0; n < STEPS; n++)
                time_reg[n] <= '0;
        end
        else if (time_we)
        begin
            time_reg[time_waddr] <= time_wdata;
        end
    end

    // Coefficient scratch
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_reg[j_reg[HW-1:0]] <= c_reg;
    end

    // Clearing pass over the element memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_LAST)
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Element memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (fsm_we)
            mem[fsm_waddr] <= fsm_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    hrlp_rdiv u_rdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    hrlp_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    `HRLP_ASSERT_IMP(a_clear_holds_idle, clr_busy_reg, state_reg == S_IDLE, "item taken during memory clear")
    `HRLP_ASSERT_NXT(a_head_only_in_exec, state_reg != S_EXEC, $stable(head_reg), "head moved outside execute")
    `HRLP_ASSERT_IMP(a_div_nonzero_den, div_start, den_reg != 32'sd0, "division started on zero denominator")
    `HRLP_ASSERT_IMP(a_wait_div_idle_units, state_reg == S_IDLE, !div_done && !sq_done, "unit finished while sequencer idle")

endmodule

### tb/sv/tb.sv
// Testbench for the history ring Lagrange predictor: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb;
    import hrlp_pkg::*;

    localparam int RING  = 8;
    localparam int NVARS = 16;
    localparam int QBITS = 16;

    // Ring model and store of awaited results
    class ring_scoreboard;
        int unsigned head;
        int          stamp[RING];
        int          elem[RING*NVARS];
        longint      coef[RING];
        logic [2:0]  order_reg;
        logic [30:0] gap_limit;
        out_item_t   awaited[$];
        int          n_bad, n_ok, n_faults, n_heavy;

        function new();
            head = 0;
            foreach (stamp[i]) stamp[i] = 0;
            foreach (elem[i]) elem[i] = 0;
            order_reg = PRED_ORDER_RST;
            gap_limit = MAX_STEP_RST;
        endfunction

        function void write_reg(logic idx, logic [31:0] d);
            if (idx == CFG_PRED_ORDER)
                order_reg = d[2:0];
            else
                gap_limit = d[30:0];
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Round to nearest, ties away from zero
        function longint div_round(longint p, longint d);
            longint unsigned up, ud, q;
            up = (p < 0) ? longint'(-(p + 1)) + 1 : p;
            ud = (d < 0) ? longint'(-(d + 1)) + 1 : d;
            q = (up + ud / 2) / ud;
            return ((p < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function int unsigned slot(int off);
            int s;
            if (off < 2 - RING) off = 2 - RING;
            if (off > 1) off = 1;
            s = int'(head) + off;
            if (s >= RING) s -= RING;
            if (s < 0) s += RING;
            return s;
        endfunction

        function longint stamp_at(int off);
            return longint'(stamp[slot(off)]);
        endfunction

        function int eff_order();
            int o;
            o = int'(order_reg);
            if (o < 1) o = 1;
            if (o > RING - 2) o = RING - 2;
            return o;
        endfunction

        // Lagrange weights; returns 1 on equal time stamps
        function bit weights(longint newx, int o);
            longint c, xj, xi, num, den;
            for (int j = 0; j <= o; j++)
            begin
                c = 64'sd1 << QBITS;
                xj = stamp_at(j - o);
                for (int i = 0; i <= o; i++)
                begin
                    if (i == j) continue;
                    xi = stamp_at(i - o);
                    num = sat32(newx - xi);
                    den = sat32(xj - xi);
                    if (den == 0) return 1;
                    c = sat32(div_round(c * num, den));
                end
                coef[j] = c;
            end
            return 0;
        endfunction

        function longint extrapolate(int v, int o);
            longint acc;
            acc = 0;
            for (int k = 0; k <= o; k++)
                acc += div_round(longint'(elem[slot(k - o)*NVARS + v]) * coef[k],
                                 64'sd1 << QBITS);
            return sat32(acc);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // Apply one accepted operation and queue its result
        function void note(in_item_t it);
            out_item_t   r;
            int          off, o, s, ns;
            longint      dat, nt, d;
            longint unsigned m, sq, sum, rt;
            off = $signed(it.offset);
            dat = longint'($signed(it.data_value));
            s = slot(off);
            r = '0;
            case (it.operation)
                OP_WR_ELEM: elem[s*NVARS + it.var_index] = int'(dat);
                OP_RD_ELEM: r.read_value = elem[s*NVARS + it.var_index];
                OP_WR_TIME: stamp[s] = int'(dat);
                OP_RD_TIME: r.read_value = stamp[s];
                OP_PROCEED:
                begin
                    if (dat != 0)
                    begin
                        nt = sat32(stamp_at(0) + dat);
                        if (dat > 0) head = (head + 1 >= RING) ? 0 : head + 1;
                        else head = (head == 0) ? RING - 1 : head - 1;
                        stamp[head] = int'(nt);
                    end
                end
                OP_PREDICT:
                begin
                    n_heavy++;
                    o = eff_order();
                    nt = sat32(stamp_at(0) + dat);
                    if (weights(nt, o))
                        r.div_fault = 1'b1;
                    else
                    begin
                        ns = slot(1);
                        for (int v = 0; v < NVARS; v++)
                            elem[ns*NVARS + v] = int'(extrapolate(v, o));
                        stamp[ns] = int'(nt);
                    end
                end
                OP_ERROR:
                begin
                    n_heavy++;
                    o = eff_order();
                    if (weights(stamp_at(1), o))
                        r.div_fault = 1'b1;
                    else
                    begin
                        ns = slot(1);
                        sum = 0;
                        for (int v = 0; v < NVARS; v++)
                        begin
                            d = extrapolate(v, o) - longint'(elem[ns*NVARS + v]);
                            m = (d < 0) ? -d : d;
                            sq = m * m;
                            sum = (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ?
                                  64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
                        end
                        rt = int_sqrt(sum);
                        r.read_value = (rt > 64'd2147483647) ? 32'h7FFF_FFFF : rt[31:0];
                    end
                end
                OP_COUNT:
                begin
                    r.seq_count = 4'd1;
                    for (int i = 0; i <= RING - 2; i++)
                    begin
                        if (stamp_at(-i) <= stamp_at(-i - 1) ||
                            stamp_at(-i) - stamp_at(-i - 1) > longint'(gap_limit))
                            break;
                        r.seq_count++;
                    end
                end
                OP_RESTART: foreach (stamp[i]) stamp[i] = 0;
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.div_fault) n_faults++;
            if (got.read_value !== want.read_value || got.seq_count !== want.seq_count ||
                got.div_fault !== want.div_fault)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: result %0d: value %h/%h count %0d/%0d fault %b/%b (exp/got)",
                             n_ok + n_bad, want.read_value, got.read_value,
                             want.seq_count, got.seq_count, want.div_fault, got.div_fault);
            end
            else
                n_ok++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    ring_scoreboard sb;
    int   n_sent;
    logic quiet;
    logic held;
    int   hold_cnt;

    history_ring_lagrange_predictor_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result side: check each transfer, random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_data);
        if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (!held && n_sent >= 300)
        begin
            held      <= 1'b1;
            hold_cnt  <= 300;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 22);
    end

    // Offer one operation, with an occasional gap first
    task automatic send(logic [3:0] op, int off, int var_i, logic [31:0] d);
        in_item_t it;
        it.operation  = op;
        it.offset     = off[3:0];
        it.var_index  = var_i[3:0];
        it.data_value = d;
        if (!quiet && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sb.note(it);
        n_sent++;
        quiet = (n_sent >= 500 && n_sent < 650);
    endtask

    // Register write once every result is back
    task automatic write_cfg(logic idx, logic [31:0] d);
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    function automatic logic [31:0] elem_value();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(0, 2*1048576) - 1048576;
    endfunction

    // Well-formed run: step times, fill the points, predict, then inspect
    task automatic run_sequence();
        int o;
        o = sb.eff_order();
        repeat (o + 1 + $urandom_range(0, 2))
            send(OP_PROCEED, $urandom_range(0, 15), $urandom_range(0, 15),
                 ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 3*65536));
        for (int k = -o; k <= 0; k++)
            repeat ($urandom_range(1, 3))
                send(OP_WR_ELEM, k, $urandom_range(0, 15), elem_value());
        send(OP_PREDICT, $urandom_range(0, 15), 0, $urandom_range(1, 3*65536));
        send(OP_WR_ELEM, 1, $urandom_range(0, 15), elem_value());
        send(OP_ERROR, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        send(OP_COUNT, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        send(OP_RD_ELEM, 1, $urandom_range(0, 15), $urandom);
        send(OP_RD_TIME, int'($urandom_range(0, 9)) - 8, 0, $urandom);
    endtask

    task automatic random_phase(int goal);
        while (n_sent < goal)
        begin
            if ($urandom_range(99) < 70)
                run_sequence();
            else
                send($urandom_range(1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8)),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int waited;
        sb        = new();
        n_sent    = 0;
        quiet     = 1'b0;
        held      = 1'b0;
        hold_cnt  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PRED_ORDER;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, faults on equal times, saturation, odd codes
        send(OP_COUNT, 0, 0, 0);
        send(OP_PREDICT, 0, 0, 32'h0001_0000);
        send(OP_ERROR, 0, 0, 0);
        send(OP_WR_ELEM, -8, 0, 32'h8000_0000);
        send(OP_WR_ELEM, 7, 15, 32'h7FFF_FFFF);
        send(OP_RD_ELEM, -6, 0, 0);
        send(OP_RD_ELEM, 1, 15, 32'hFFFF_FFFF);
        send(OP_WR_TIME, 1, 0, 32'h7FFF_FFFF);
        send(OP_RD_TIME, 7, 0, 0);
        send(OP_PROCEED, 0, 0, 32'h7FFF_FFFF);
        send(OP_PROCEED, 0, 0, 32'hFFFF_FFFF);
        send(OP_PROCEED, 0, 0, 0);
        send(OP_RD_TIME, 0, 0, 0);
        send(OP_WR_TIME, -6, 0, 32'h8000_0000);
        send(OP_PROCEED, 0, 0, 32'h8000_0000);
        send(OP_COUNT, 0, 0, 0);
        send(4'd9, 3, 5, 32'h1234_5678);
        send(4'd15, -1, 15, 32'hFFFF_FFFF);
        send(OP_RESTART, 0, 0, 0);
        send(OP_RD_TIME, 1, 0, 0);
        send(OP_PROCEED, 0, 0, 32'h0001_0000);
        send(OP_PROCEED, 0, 0, 32'h0001_0000);
        send(OP_PROCEED, 0, 0, 32'h0001_0000);
        send(OP_PREDICT, 0, 0, 32'h0001_0000);
        send(OP_COUNT, 0, 0, 0);

        random_phase(160);
        write_cfg(CFG_PRED_ORDER, 32'd0);
        write_cfg(CFG_MAX_STEP, 32'd0);
        random_phase(320);
        write_cfg(CFG_PRED_ORDER, 32'd7);
        write_cfg(CFG_MAX_STEP, 32'h7FFF_FFFF);
        random_phase(450);
        write_cfg(CFG_PRED_ORDER, 32'd1);
        write_cfg(CFG_MAX_STEP, 32'd131072);
        random_phase(650);
        write_cfg(CFG_PRED_ORDER, 32'd3);
        write_cfg(CFG_MAX_STEP, $urandom);
        random_phase(820);
        write_cfg(CFG_PRED_ORDER, 32'd6);
        write_cfg(CFG_MAX_STEP, 32'd262144);
        random_phase(960);
        write_cfg(CFG_PRED_ORDER, $urandom);
        write_cfg(CFG_MAX_STEP, $urandom);
        random_phase(1150);
        in_valid <= 1'b0;

        waited = 0;
        while (sb.awaited.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (sb.awaited.size() != 0)
        begin
            sb.n_bad++;
            $display("ERROR: %0d results never arrived", sb.awaited.size());
        end
        $display("Covered %0d operations (%0d predict/error, %0d div faults) over 7 settings",
                 n_sent, sb.n_heavy, sb.n_faults);
        $display("%0d results matched, %0d mismatches", sb.n_ok, sb.n_bad);
        if (sb.n_bad == 0)
            $display("PASS history_ring_lagrange_predictor_core");
        else
            $display("FAIL history_ring_lagrange_predictor_core");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200_000_000;
        $display("FAIL history_ring_lagrange_predictor_core");
        $finish;
    end

endmodule

### history_ring_lagrange_predictor_core.f
+incdir+rtl
rtl/hrlp_pkg.sv
rtl/hrlp_rdiv.sv
rtl/hrlp_isqrt.sv
rtl/history_ring_lagrange_predictor_core.sv
tb/sv/tb.sv
